@@ rtl/ais_pkg.sv @@
package ais_pkg;

	localparam int VALUE_BITS = 64;
	localparam int OUT_BITS   = 64;
	localparam int CNT_BITS   = 14;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = QPTR_BITS + 1;

	localparam logic [CNT_BITS-1:0] MAX_CHARS_RESET = CNT_BITS'(9999);

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_UHEX = 2'd1;
	localparam logic [1:0] MODE_SDEC = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NODIG = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_MAXC = 1'b1;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	typedef struct packed {
		logic [1:0]          number_mode;
		logic [CNT_BITS-1:0] max_chars;
	} cfg_t;

	// classified character, front to back
	typedef struct packed {
		logic       start;
		logic       minus;
		logic       dig_ok;
		logic [3:0] dig;
	} tok_t;

endpackage

@@ rtl/ais_regs.sv @@
module ais_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output ais_pkg::cfg_t cfg
);
	import ais_pkg::*;

	logic  wr_en;
	cfg_t  cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_mode <= MODE_UDEC;
			cfg_q.max_chars   <= MAX_CHARS_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MODE: cfg_q.number_mode <= pwdata[1:0];
				default:  cfg_q.max_chars   <= pwdata[CNT_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE: prdata = {30'b0, cfg_q.number_mode};
			default:  prdata = {(32-CNT_BITS)'(0), cfg_q.max_chars};
		endcase
	end

endmodule

@@ rtl/ais_front.sv @@
module ais_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    char_code,
	input  logic          start_req,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    number_mode,
	output ais_pkg::tok_t tok,
	output logic          tok_valid,
	input  logic          tok_pop
);
	import ais_pkg::*;

	tok_t                 q_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	tok_t                 cls;
	logic                 do_push, do_pop, hex;

	assign hex = number_mode == MODE_UHEX;

	always_comb begin
		cls.start  = start_req;
		cls.minus  = char_code == CH_MINUS;
		cls.dig_ok = 1'b0;
		cls.dig    = char_code[3:0];
		if (char_code inside {[CH_0:CH_9]}) begin
			cls.dig_ok = 1'b1;
		end else if (hex && (char_code inside {[CH_LA:CH_LF], [CH_UA:CH_UF]})) begin
			// low nibble of a..f / A..F is 1..6
			cls.dig_ok = 1'b1;
			cls.dig    = char_code[3:0] + 4'd9;
		end
	end

	assign full      = cnt_q == QCNT_BITS'(QDEPTH);
	assign tok_valid = cnt_q != '0;
	assign tok       = q_q[rd_q];
	assign do_push   = push & ~full;
	assign do_pop    = tok_pop & tok_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/ais_back.sv @@
module ais_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ais_pkg::tok_t                tok,
	input  logic                         tok_valid,
	output logic                         tok_pop,
	input  ais_pkg::cfg_t                cfg,
	input  logic                         pop,
	output logic                         empty,
	output logic [ais_pkg::OUT_BITS-1:0] value,
	output logic [1:0]                   status,
	output logic                         char_taken
);
	import ais_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_DIGITS} phase_t;

	typedef struct packed {
		logic                  ovf;
		logic                  nodig;
		logic                  neg;
		logic                  signed_m;
		logic                  taken;
		logic [VALUE_BITS-1:0] acc;
	} fin_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] value;
		logic [1:0]          status;
		logic                taken;
	} res_t;

	localparam logic [VALUE_BITS-1:0] HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

	phase_t                phase_q, ph, ph_n;
	logic [VALUE_BITS-1:0] acc_q, acc, acc_n;
	logic [CNT_BITS-1:0]   used_q, used, used_n, used_inc;
	logic                  neg_q, neg, neg_n;
	logic [VALUE_BITS+3:0] prod;
	logic                  go, fire, hex, sgn;
	fin_t                  fin, fin_s1;
	logic                  fin_v_s1;
	res_t                  res;
	res_t                  rq_q [QDEPTH];
	logic [QPTR_BITS-1:0]  rwr_q, rrd_q;
	logic [QCNT_BITS-1:0]  rcnt_q;
	logic                  do_pop;

	assign hex = cfg.number_mode == MODE_UHEX;
	assign sgn = cfg.number_mode == MODE_SDEC;

	// hold a slot for the transaction already in s1
	assign go      = tok_valid && ((rcnt_q + QCNT_BITS'(fin_v_s1)) < QCNT_BITS'(QDEPTH));
	assign tok_pop = go;

	always_comb begin
		ph   = phase_q;
		acc  = acc_q;
		used = used_q;
		neg  = neg_q;
		if (tok.start) begin
			ph   = PH_FIRST;
			acc  = '0;
			used = '0;
			neg  = 1'b0;
		end

		if (hex) prod = {acc, 4'b0} + (VALUE_BITS+4)'(tok.dig);
		else     prod = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + (VALUE_BITS+4)'(tok.dig);
		used_inc = used + 1'b1;

		ph_n      = ph;
		acc_n     = acc;
		used_n    = used;
		neg_n     = neg;
		fire      = 1'b0;
		fin.ovf   = 1'b0;
		fin.taken = 1'b0;

		case (ph)
			PH_IDLE: ;
			default: begin
				if (used >= cfg.max_chars) begin
					fire = 1'b1;
				end else begin
					if (ph == PH_FIRST) ph_n = PH_DIGITS;
					if (ph == PH_FIRST && sgn && tok.minus) begin
						neg_n  = 1'b1;
						used_n = CNT_BITS'(1);
						if (cfg.max_chars <= CNT_BITS'(1)) begin
							fire      = 1'b1;
							fin.taken = 1'b1;
						end
					end else if (!tok.dig_ok) begin
						fire = 1'b1;
					end else if (|prod[VALUE_BITS+3:VALUE_BITS]) begin
						fire      = 1'b1;
						fin.ovf   = 1'b1;
						fin.taken = 1'b1;
					end else begin
						acc_n  = prod[VALUE_BITS-1:0];
						used_n = used_inc;
						if (used_inc >= cfg.max_chars) begin
							fire      = 1'b1;
							fin.taken = 1'b1;
						end
					end
				end
			end
		endcase
		if (fire) ph_n = PH_IDLE;

		fin.nodig    = used_n <= CNT_BITS'(neg_n);
		fin.neg      = neg_n;
		fin.signed_m = sgn;
		fin.acc      = acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= '0;
			used_q   <= '0;
			neg_q    <= 1'b0;
			fin_v_s1 <= 1'b0;
		end else begin
			fin_v_s1 <= go && fire;
			if (go) begin
				phase_q <= ph_n;
				acc_q   <= acc_n;
				used_q  <= used_n;
				neg_q   <= neg_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && fire) fin_s1 <= fin;
	end

	// s2: status and sign fix-up of the finished number
	always_comb begin
		res.taken  = fin_s1.taken;
		res.value  = '0;
		res.status = ST_OK;
		if (fin_s1.ovf) begin
			res.status = ST_OVF;
		end else if (fin_s1.nodig) begin
			res.status = ST_NODIG;
		end else if (fin_s1.signed_m && fin_s1.neg) begin
			if (fin_s1.acc > HALF) res.status = ST_RANGE;
			else                   res.value  = OUT_BITS'(0) - OUT_BITS'(fin_s1.acc);
		end else if (fin_s1.signed_m && fin_s1.acc[VALUE_BITS-1]) begin
			res.status = ST_RANGE;
		end else begin
			res.value = OUT_BITS'(fin_s1.acc);
		end
	end

	assign empty      = rcnt_q == '0;
	assign value      = rq_q[rrd_q].value;
	assign status     = rq_q[rrd_q].status;
	assign char_taken = rq_q[rrd_q].taken;
	assign do_pop     = pop & ~empty;

	always_ff @(posedge clk) begin
		if (fin_v_s1) rq_q[rwr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= '0;
			rrd_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (fin_v_s1) rwr_q <= rwr_q + 1'b1;
			if (do_pop)   rrd_q <= rrd_q + 1'b1;
			case ({fin_v_s1, do_pop})
				2'b10:   rcnt_q <= rcnt_q + 1'b1;
				2'b01:   rcnt_q <= rcnt_q - 1'b1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

endmodule

@@ rtl/ascii_integer_scanner_core.sv @@
// ASCII integer scanner: one character per input transaction, one result per number.
// Input queue: char_code/start_req are taken when push is high and full is low.
// Result queue: value/status/char_taken are valid while empty is low; pop takes them.
// Config (APB, pready tied high): 0x0 number_mode, 0x4 max_chars; write only when idle.
// Throughput: one character per cycle, sustained while the result queue has room.
// The digit step (acc * base + digit, shift-and-add) and the scan state update are
// combinational in the back end and registered together. A character that ends
// a number is held in the input queue, then in the scan stage register. Status and
// sign fix-up is combinational off that register and writes the result queue.
// Both queues are 4 deep. When the receiver stalls, the result queue fills, the scan
// stage holds, and full rises once the input queue is full as well; nothing is lost.
// Reset clears both queues, returns the scanner to idle, and sets number_mode to
// unsigned decimal and max_chars to 9999. No clearing pass is needed after reset.
module ascii_integer_scanner_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic [7:0]                   char_code,
	input  logic                         start_req,
	input  logic                         push,
	output logic                         full,
	output logic [ais_pkg::OUT_BITS-1:0] value,
	output logic [1:0]                   status,
	output logic                         char_taken,
	output logic                         empty,
	input  logic                         pop
);
	import ais_pkg::*;

	cfg_t cfg;
	tok_t tok;
	logic tok_valid, tok_pop;

	ais_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ais_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.start_req   (start_req),
		.push        (push),
		.full        (full),
		.number_mode (cfg.number_mode),
		.tok         (tok),
		.tok_valid   (tok_valid),
		.tok_pop     (tok_pop)
	);

	ais_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok        (tok),
		.tok_valid  (tok_valid),
		.tok_pop    (tok_pop),
		.cfg        (cfg),
		.pop        (pop),
		.empty      (empty),
		.value      (value),
		.status     (status),
		.char_taken (char_taken)
	);

	a_maxc_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_MAXC)
		|=> cfg.max_chars == $past(pwdata[CNT_BITS-1:0]))
		else $error("max_chars register not updated by write");

	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_MODE)
		|=> cfg.number_mode == $past(pwdata[1:0]))
		else $error("number_mode register not updated by write");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> value == '0)
		else $error("nonzero value on an error result");

	a_ovf_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OVF) |-> char_taken)
		else $error("overflow result without the digit consumed");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ais_pkg::*;

	localparam logic [1:0]  MODE_ALT = 2'd3;	// unused code, scans as unsigned decimal
	localparam logic [63:0] VAL_MAX  = 64'((65'd1 << VALUE_BITS) - 65'd1);
	localparam logic [63:0] VAL_HALF = 64'(65'd1 << (VALUE_BITS - 1));
	localparam int          SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_LEAD, SCAN_DIGITS} scan_phase_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic        taken;
	} number_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  char_code = '0;
	logic        start_req = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] value;
	logic [1:0]  status;
	logic        char_taken;
	logic        empty;
	logic        pop = 1'b0;

	ascii_integer_scanner_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.char_code  (char_code),
		.start_req  (start_req),
		.push       (push),
		.full       (full),
		.value      (value),
		.status     (status),
		.char_taken (char_taken),
		.empty      (empty),
		.pop        (pop)
	);

	// scanner state as the predictor sees it
	logic [1:0]  cur_mode  = MODE_UDEC;
	logic [13:0] cur_width = MAX_CHARS_RESET;
	scan_phase_t cur_phase = SCAN_IDLE;
	logic [63:0] cur_acc   = '0;
	logic [13:0] cur_used  = '0;
	logic        cur_neg   = 1'b0;

	number_res_t pending_numbers[$];
	number_res_t want;

	bit calm = 1'b0;
	int gap_pct = 0;
	int chars_sent = 0;
	int numbers_seen = 0;
	int mismatch_cnt = 0;
	int stray_cnt = 0;
	int status_cnt[4];

	string hex_digits = "0123456789abcdefABCDEF";
	string edge_numbers[10] = '{
		"18446744073709551615", "18446744073709551616", "99999999999999999999",
		"9223372036854775807", "9223372036854775808", "9223372036854775809",
		"ffffffffffffffff", "FFFFFFFFFFFFFFFF0", "10000000000000000",
		"00000000000000000000000"
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic int digit_of(logic [7:0] c, logic hexm);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (hexm && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (hexm && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic void queue_number(logic [63:0] v, logic [1:0] st, logic tk);
		number_res_t r;
		r.value = v;
		r.status = st;
		r.taken = tk;
		pending_numbers.push_back(r);
		cur_phase = SCAN_IDLE;
	endfunction

	function automatic void close_number(logic tk);
		if (cur_used <= 14'(cur_neg))
			queue_number('0, ST_NODIG, tk);
		else if (cur_mode == MODE_SDEC && cur_neg) begin
			if (cur_acc > VAL_HALF)
				queue_number('0, ST_RANGE, tk);
			else
				queue_number(64'd0 - cur_acc, ST_OK, tk);
		end else if (cur_mode == MODE_SDEC && cur_acc > VAL_HALF - 64'd1)
			queue_number('0, ST_RANGE, tk);
		else
			queue_number(cur_acc, ST_OK, tk);
	endfunction

	function automatic void scan_char(logic [7:0] c, logic s);
		logic        hexm;
		logic [63:0] base;
		int          d;
		hexm = (cur_mode == MODE_UHEX);
		base = hexm ? 64'd16 : 64'd10;
		if (s) begin
			cur_phase = SCAN_LEAD;
			cur_acc = '0;
			cur_used = '0;
			cur_neg = 1'b0;
		end
		if (cur_phase == SCAN_IDLE)
			return;
		if (cur_used >= cur_width) begin
			close_number(1'b0);
			return;
		end
		if (cur_phase == SCAN_LEAD) begin
			cur_phase = SCAN_DIGITS;
			if (cur_mode == MODE_SDEC && c == CH_MINUS) begin
				cur_neg = 1'b1;
				cur_used = 14'd1;
				if (cur_used >= cur_width)
					close_number(1'b1);
				return;
			end
		end
		d = digit_of(c, hexm);
		if (d < 0) begin
			close_number(1'b0);
			return;
		end
		if (cur_acc > (VAL_MAX - 64'(d)) / base) begin
			queue_number('0, ST_OVF, 1'b1);
			return;
		end
		cur_acc = cur_acc * base + 64'(d);
		cur_used = cur_used + 14'd1;
		if (cur_used >= cur_width)
			close_number(1'b1);
	endfunction

	// ---------------- result side ----------------

	initial begin
		forever begin
			pop <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			numbers_seen++;
			if (pending_numbers.size() == 0) begin
				stray_cnt++;
				if (mismatch_cnt + stray_cnt <= 10)
					$display("unexpected result: value %h status %0d taken %0b",
						value, status, char_taken);
			end else begin
				want = pending_numbers.pop_front();
				status_cnt[want.status]++;
				if (value !== want.value || status !== want.status ||
						char_taken !== want.taken) begin
					mismatch_cnt++;
					if (mismatch_cnt + stray_cnt <= 10)
						$display("mismatch: value %h/%h status %0d/%0d taken %0b/%0b (exp/got)",
							want.value, value, want.status, status, want.taken, char_taken);
				end
			end
		end
	end

	// ---------------- drivers ----------------

	task automatic send_char(input logic [7:0] c, input logic s);
		if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_code <= c;
		start_req <= s;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		scan_char(c, s);
		chars_sent++;
	endtask

	task automatic send_text(input string t, input logic s);
		for (int i = 0; i < t.len(); i++)
			send_char(t[i], s && i == 0);
	endtask

	// stop pushing, let every expected number come out, then let the pipe empty
	task automatic settle();
		push <= 1'b0;
		while (pending_numbers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		paddr <= {idx, 2'b00};
		pwdata <= data;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MODE)
			cur_mode = data[1:0];
		else
			cur_width = data[13:0];
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		if ($urandom_range(0, 29) == 0)
			return 8'($urandom_range(0, 255));
		if (cur_mode == MODE_UHEX)
			return hex_digits[$urandom_range(0, 21)];
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_end();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return " ";
			2: return ",";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one number-shaped run of characters, or a burst of noise
	task automatic send_number();
		int    kind;
		int    len;
		logic  first;
		string t;
		kind = $urandom_range(0, 9);
		first = 1'b1;
		if (kind == 0) begin
			repeat ($urandom_range(1, 6))
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			return;
		end
		if ($urandom_range(0, 3) == 0 || (cur_mode == MODE_SDEC && $urandom_range(0, 1) == 0)) begin
			send_char(CH_MINUS, 1'b1);
			first = 1'b0;
		end
		if (kind == 1) begin
			t = edge_numbers[$urandom_range(0, 9)];
			for (int i = 0; i < t.len(); i++) begin
				send_char(t[i], first);
				first = 1'b0;
			end
		end else begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				send_char(pick_digit(), first);
				first = 1'b0;
			end
		end
		// sometimes no terminator: the next start drops the number
		if (first || $urandom_range(0, 5) != 0)
			send_char(pick_end(), first);
	endtask

	task automatic pick_config();
		int r;
		r = $urandom_range(0, 9);
		write_reg(REG_MODE, ($urandom_range(0, 7) == 0) ? MODE_ALT : 32'($urandom_range(0, 2)));
		if (r < 5)
			write_reg(REG_MAXC, 32'(MAX_CHARS_RESET));
		else if (r < 8)
			write_reg(REG_MAXC, $urandom_range(1, 22));
		else if (r == 8)
			write_reg(REG_MAXC, $urandom_range(0, 2));
		else
			write_reg(REG_MAXC, $urandom_range(10000, 16383));
		case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 40;
		endcase
	endtask

	// ---------------- tests ----------------

	task automatic test_decimal_basics();
		send_text("7,", 1'b1);
		send_char("x", 1'b0);			// idle, no start: dropped
		send_char("1", 1'b1);
		send_char("2", 1'b1);			// restart abandons the first number
		send_char(8'h00, 1'b0);
		send_char(CH_MINUS, 1'b1);		// minus is no digit in unsigned mode
		settle();
	endtask

	task automatic test_hex();
		write_reg(REG_MODE, MODE_UHEX);
		send_text("fA", 1'b1);
		send_char(8'h00, 1'b0);
		send_char("G", 1'b1);
		settle();
	endtask

	task automatic test_signed();
		write_reg(REG_MODE, MODE_SDEC);
		send_text("-5 ", 1'b1);
		send_text("-0", 1'b1);
		send_char(8'h00, 1'b0);
		send_text("- ", 1'b1);			// sign only
		settle();
		write_reg(REG_MODE, MODE_ALT);
		send_text("9", 1'b1);
		send_char(8'h00, 1'b0);
		settle();
	endtask

	task automatic test_width_limits();
		write_reg(REG_MODE, MODE_SDEC);
		write_reg(REG_MAXC, 1);
		send_char(CH_MINUS, 1'b1);		// sign fills the width
		settle();
		write_reg(REG_MAXC, 0);
		send_char("5", 1'b1);
		settle();
		write_reg(REG_MODE, MODE_UDEC);
		write_reg(REG_MAXC, 2);
		send_text("123", 1'b1);
		settle();
		write_reg(REG_MAXC, 16383);
		send_text("42 ", 1'b1);
		settle();
	endtask

	task automatic test_width_lowered();
		write_reg(REG_MAXC, 32'(MAX_CHARS_RESET));
		send_text("12", 1'b1);
		settle();
		write_reg(REG_MAXC, 1);			// below the chars already used
		send_char("3", 1'b0);
		settle();
	endtask

	task automatic test_random_text(input int upto);
		int phase_end;
		while (chars_sent < upto) begin
			settle();
			pick_config();
			phase_end = chars_sent + $urandom_range(30, 70);
			while (chars_sent < phase_end)
				send_number();
		end
		settle();
	endtask

	task automatic test_steady_stream();
		calm = 1'b1;
		gap_pct = 0;
		test_random_text(chars_sent + 100);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decimal_basics();
		test_hex();
		test_signed();
		test_width_limits();
		test_width_lowered();
		test_random_text(620);
		test_steady_stream();
		$display("summary: %0d characters pushed, %0d numbers returned", chars_sent, numbers_seen);
		$display("summary: ok %0d, no digits %0d, overflow %0d, out of range %0d",
			status_cnt[ST_OK], status_cnt[ST_NODIG], status_cnt[ST_OVF], status_cnt[ST_RANGE]);
		if (mismatch_cnt == 0 && stray_cnt == 0 && pending_numbers.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
